FILE: hw/rtl/rrts_pkg.sv
// ============================================================================
// rrts_pkg: shared types and constants of the round-robin task switcher
// Holds the result kinds, the input op codes, the controller states, the
// command and status structs and the initial frame contents.
// ============================================================================
package rrts_pkg;

    localparam int SLOTS_DEF       = 8;
    localparam int STACK_BYTES_DEF = 4096;

    localparam int          FRAME_WORDS = 14;
    localparam int          FRAME_IDX_W = 4;
    localparam logic [31:0] FRAME_STEP  = 32'd4;

    localparam logic [FRAME_IDX_W-1:0] FIDX_FLAGS = FRAME_IDX_W'(0);
    localparam logic [FRAME_IDX_W-1:0] FIDX_CODE  = FRAME_IDX_W'(1);
    localparam logic [FRAME_IDX_W-1:0] FIDX_ENTRY = FRAME_IDX_W'(2);
    localparam logic [FRAME_IDX_W-1:0] FIDX_LAST  = FRAME_IDX_W'(FRAME_WORDS - 1);

    localparam logic [31:0] FRAME_FLAGS_WORD = 32'h0000_0202;
    localparam logic [31:0] FRAME_CODE_WORD  = 32'h0000_0008;
    localparam logic [31:0] FRAME_DATA_WORD  = 32'h0000_0010;

    localparam logic OP_SWITCH = 1'b0;
    localparam logic OP_SPAWN  = 1'b1;

    typedef enum logic [1:0] {
        KIND_RESUME  = 2'd0,
        KIND_WRITE   = 2'd1,
        KIND_REFUSED = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SW_WRITE,
        ST_SW_READ,
        ST_SW_RESUME,
        ST_REFUSE,
        ST_SPAWN_SETUP,
        ST_SPAWN_EMIT
    } state_t;

    typedef struct packed {
        logic                   capture;
        logic                   sw_write;
        logic                   ram_read;
        logic                   load_resume;
        logic                   load_refuse;
        logic                   setup;
        logic                   emit;
        logic                   commit;
        logic [FRAME_IDX_W-1:0] frame_idx;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic table_full;
    } status_t;

    function automatic logic [31:0] frame_word(input logic [FRAME_IDX_W-1:0] idx,
                                               input logic [31:0] entry);
        logic [31:0] w;
        w = 32'd0;
        case (idx)
            FIDX_FLAGS: w = FRAME_FLAGS_WORD;
            FIDX_CODE:  w = FRAME_CODE_WORD;
            FIDX_ENTRY: w = entry;
            FIDX_LAST:  w = FRAME_DATA_WORD;
            default:    w = 32'd0;
        endcase
        return w;
    endfunction

endpackage

FILE: hw/rtl/round_robin_task_switcher_top.sv
// ============================================================================
// round_robin_task_switcher_top: round-robin context switch scheduler
// Keeps saved stack pointers for up to SLOTS tasks. A switch stores the
// interrupted pointer and returns the next task's pointer; a spawn emits the
// fourteen initial frame writes of a new task, or a refusal when full.
// ============================================================================
// One item is handled at a time. A switch writes and then reads the saved
// pointer RAM, whose read is registered, and loads its result once the
// output is free. After a setup step a spawn emits one transfer per cycle
// while the output is free, fourteen in all; a full table gives a refusal.
// The result register lets the block take a new item while the last result
// still waits. Slot zero holds the reset task and spawns fill from slot one,
// so the round-robin step wraps at the number of tasks taken.
module round_robin_task_switcher_top #(
    parameter int SLOTS       = rrts_pkg::SLOTS_DEF,
    parameter int STACK_BYTES = rrts_pkg::STACK_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // sp_value [31:0], entry_addr [63:32]
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // value [31:0], write_data [63:32]
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast
);
    import rrts_pkg::*;

    cmd_t    cmd;
    status_t st;

    rrts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(s_tvalid),
        .in_op   (s_tuser),
        .in_ready(s_tready),
        .st      (st),
        .cmd     (cmd)
    );

    rrts_datapath #(
        .SLOTS      (SLOTS),
        .STACK_BYTES(STACK_BYTES)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_sp_value   (s_tdata[31:0]),
        .in_entry_addr (s_tdata[63:32]),
        .cmd           (cmd),
        .st            (st),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_kind      (m_tuser),
        .out_value     (m_tdata[31:0]),
        .out_write_data(m_tdata[63:32]),
        .out_last      (m_tlast)
    );

endmodule

FILE: hw/rtl/rrts_ram.sv
// ============================================================================
// rrts_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read that holds its
// data until the next read.
// ============================================================================
module rrts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/rrts_ctrl.sv
// ============================================================================
// rrts_ctrl: controller of the round-robin task switcher
// Sequences switch and spawn operations and counts the frame words of a
// spawn, issuing commands to the datapath.
// ============================================================================
module rrts_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic             in_op,
    output logic             in_ready,
    input  rrts_pkg::status_t st,
    output rrts_pkg::cmd_t   cmd
);
    import rrts_pkg::*;

    state_t                 state_reg, state_next;
    logic [FRAME_IDX_W-1:0] idx_reg, idx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (in_op == OP_SWITCH) begin
                        state_next = ST_SW_WRITE;
                    end else if (st.table_full) begin
                        state_next = ST_REFUSE;
                    end else begin
                        state_next = ST_SPAWN_SETUP;
                    end
                end
            end
            ST_SW_WRITE: state_next = ST_SW_READ;
            ST_SW_READ:  state_next = ST_SW_RESUME;
            ST_SW_RESUME: begin
                if (st.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_REFUSE: begin
                if (st.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SPAWN_SETUP: begin
                idx_next   = '0;
                state_next = ST_SPAWN_EMIT;
            end
            ST_SPAWN_EMIT: begin
                if (st.out_free) begin
                    idx_next = idx_reg + FRAME_IDX_W'(1);
                    if (idx_reg == FIDX_LAST) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd           = '0;
        cmd.frame_idx = idx_reg;
        in_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_SW_WRITE:    cmd.sw_write    = 1'b1;
            ST_SW_READ:     cmd.ram_read    = 1'b1;
            ST_SW_RESUME:   cmd.load_resume = st.out_free;
            ST_REFUSE:      cmd.load_refuse = st.out_free;
            ST_SPAWN_SETUP: cmd.setup       = 1'b1;
            ST_SPAWN_EMIT: begin
                cmd.emit   = st.out_free;
                cmd.commit = st.out_free && (idx_reg == FIDX_LAST);
            end
            default: cmd = '0;
        endcase
    end

endmodule

FILE: hw/rtl/rrts_datapath.sv
// ============================================================================
// rrts_datapath: datapath of the round-robin task switcher
// Holds the slot counters, the stack base, the saved pointer RAM, the frame
// address register and the result register.
// ============================================================================
module rrts_datapath #(
    parameter int SLOTS       = rrts_pkg::SLOTS_DEF,
    parameter int STACK_BYTES = rrts_pkg::STACK_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    input  logic [31:0]       in_sp_value,
    input  logic [31:0]       in_entry_addr,
    input  rrts_pkg::cmd_t    cmd,
    output rrts_pkg::status_t st,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        out_kind,
    output logic [31:0]       out_value,
    output logic [31:0]       out_write_data,
    output logic              out_last
);
    import rrts_pkg::*;

    localparam int          SW      = $clog2(SLOTS);
    localparam int          CW      = $clog2(SLOTS + 1);
    localparam int          CW1     = CW + 1;
    localparam logic [31:0] STACK_W = 32'(STACK_BYTES);

    logic [31:0]   base_reg;
    logic [31:0]   sp_reg;
    logic [31:0]   entry_reg;
    logic [31:0]   addr_reg;
    logic [SW-1:0] cur_reg, cur_next;
    logic [CW-1:0] taken_reg;
    logic [CW1-1:0] cur_inc;

    logic          out_valid_reg;
    kind_t         out_kind_reg;
    logic [31:0]   out_value_reg;
    logic [31:0]   out_wdata_reg;
    logic          out_last_reg;

    logic          ram_we;
    logic [SW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [31:0]   ram_rdata;
    logic [31:0]   top_offset;
    logic [31:0]   frame_addr;

    assign cur_inc    = CW1'(cur_reg) + CW1'(1);
    assign cur_next   = (cur_inc >= CW1'(taken_reg)) ? '0 : cur_inc[SW-1:0];
    assign top_offset = (32'(taken_reg) + 32'd1) * STACK_W;
    assign frame_addr = addr_reg - FRAME_STEP;

    assign st.out_free   = !out_valid_reg || out_ready;
    assign st.table_full = taken_reg >= CW'(SLOTS);

    assign ram_we    = cmd.sw_write || cmd.commit;
    assign ram_waddr = cmd.commit ? taken_reg[SW-1:0] : cur_reg;
    assign ram_wdata = cmd.commit ? frame_addr : sp_reg;

    rrts_ram #(
        .WIDTH(32),
        .DEPTH(SLOTS)
    ) u_saved_ptr (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (cmd.ram_read),
        .raddr(cur_reg),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= '0;
            cur_reg       <= '0;
            taken_reg     <= CW'(1);
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                base_reg <= cfg_wdata;
            end
            if (cmd.sw_write) begin
                cur_reg <= cur_next;
            end
            if (cmd.commit) begin
                taken_reg <= taken_reg + CW'(1);
            end
            if (cmd.load_resume || cmd.load_refuse || cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sp_reg    <= in_sp_value;
            entry_reg <= in_entry_addr;
        end
        if (cmd.setup) begin
            addr_reg <= base_reg + top_offset;
        end else if (cmd.emit) begin
            addr_reg <= frame_addr;
        end
        if (cmd.load_resume) begin
            out_kind_reg  <= KIND_RESUME;
            out_value_reg <= ram_rdata;
            out_wdata_reg <= '0;
            out_last_reg  <= 1'b1;
        end else if (cmd.load_refuse) begin
            out_kind_reg  <= KIND_REFUSED;
            out_value_reg <= '0;
            out_wdata_reg <= '0;
            out_last_reg  <= 1'b1;
        end else if (cmd.emit) begin
            out_kind_reg  <= KIND_WRITE;
            out_value_reg <= frame_addr;
            out_wdata_reg <= frame_word(cmd.frame_idx, entry_reg);
            out_last_reg  <= (cmd.frame_idx == FIDX_LAST);
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_kind       = out_kind_reg;
    assign out_value      = out_value_reg;
    assign out_write_data = out_wdata_reg;
    assign out_last       = out_last_reg;

endmodule

FILE: bench/round_robin_task_switcher_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// round_robin_task_switcher_top_tb: self-checking bench for the task switcher
// Drives switch and spawn items on the input stream, predicts the resume
// pointers, frame writes and refusals, and checks every result transfer in
// order. Directed tests cover one task, wrapped and unaligned stack bases and
// a full table; random tests mix items under sender gaps and receiver stalls.
// ============================================================================
module round_robin_task_switcher_top_tb;
    import rrts_pkg::*;

    localparam int SLOTS       = SLOTS_DEF;
    localparam int STACK_BYTES = STACK_BYTES_DEF;

    typedef struct {
        kind_t       kind;
        logic [31:0] value;
        logic [31:0] wdata;
        logic        last;
    } sched_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    sched_result_t sched_results_q[$];
    int unsigned   errors = 0;

    logic [31:0] stack_base = '0;
    logic [31:0] slot_sp [SLOTS];
    logic [SLOTS-1:0] slot_used = SLOTS'(1);
    int unsigned run_slot    = 0;
    int unsigned tasks_taken = 1;

    int unsigned burst_left = 1;
    int unsigned stall_left = 0;
    int unsigned stall_mode = 0;

    round_robin_task_switcher_top #(
        .SLOTS       (SLOTS),
        .STACK_BYTES (STACK_BYTES)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    task automatic push_result(input kind_t kind, input logic [31:0] value,
                               input logic [31:0] wdata, input logic last);
        sched_result_t r;
        r.kind  = kind;
        r.value = value;
        r.wdata = wdata;
        r.last  = last;
        sched_results_q.push_back(r);
    endtask

    task automatic predict_schedule(input logic op, input logic [31:0] sp,
                                    input logic [31:0] entry);
        int unsigned slot;
        logic [31:0] addr;
        logic [31:0] word;
        if (op == OP_SWITCH) begin
            slot_sp[run_slot] = sp;
            for (int n = 0; n < SLOTS; n++) begin
                run_slot = (run_slot + 1) % SLOTS;
                if (slot_used[run_slot]) break;
            end
            push_result(KIND_RESUME, slot_sp[run_slot], 32'd0, 1'b1);
        end else if (tasks_taken >= SLOTS) begin
            push_result(KIND_REFUSED, 32'd0, 32'd0, 1'b1);
        end else begin
            slot = tasks_taken;
            tasks_taken++;
            slot_used[slot] = 1'b1;
            addr = stack_base + 32'((slot + 1) * STACK_BYTES);
            for (int k = 0; k < FRAME_WORDS; k++) begin
                addr = addr - FRAME_STEP;
                case (k)
                    0:               word = FRAME_FLAGS_WORD;
                    1:               word = FRAME_CODE_WORD;
                    2:               word = entry;
                    FRAME_WORDS - 1: word = FRAME_DATA_WORD;
                    default:         word = 32'd0;
                endcase
                push_result(KIND_WRITE, addr, word, k == FRAME_WORDS - 1);
            end
            slot_sp[slot] = addr;
        end
    endtask

    task automatic send_item(input logic op, input logic [31:0] sp,
                             input logic [31:0] entry);
        s_tvalid <= 1'b1;
        s_tdata  <= {entry, sp};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        predict_schedule(op, sp, entry);
        burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (sched_results_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_stack_base(input logic [31:0] base);
        cfg_we    <= 1'b1;
        cfg_wdata <= base;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        stack_base = base;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic run_random_items(input int unsigned count, input int unsigned spawn_odds);
        for (int unsigned i = 0; i < count; i++) begin
            send_item(($urandom_range(1, spawn_odds) == 1) ? OP_SPAWN : OP_SWITCH,
                      pick_word(), pick_word());
            if (i == count / 2) wait_results_drained();
        end
    endtask

    task automatic test_single_task_switch();
        write_stack_base(32'h0000_0000);
        send_item(OP_SWITCH, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(OP_SWITCH, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(OP_SWITCH, 32'hA5A5_5A5A, 32'h1234_5678);
    endtask

    task automatic test_spawn_base_zero();
        send_item(OP_SPAWN, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(OP_SWITCH, 32'h0000_1000, 32'h0);
        send_item(OP_SWITCH, 32'h8000_0000, 32'h0);
        send_item(OP_SWITCH, 32'h7FFF_FFFC, 32'h0);
        wait_results_drained();
    endtask

    task automatic test_spawn_wrapped_base();
        write_stack_base(32'hFFFF_FFF0);
        send_item(OP_SPAWN, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(OP_SWITCH, 32'h1111_1110, 32'hFFFF_FFFF);
        send_item(OP_SWITCH, 32'h2222_2220, 32'hFFFF_FFFF);
        send_item(OP_SWITCH, 32'h3333_3330, 32'hFFFF_FFFF);
        wait_results_drained();
    endtask

    task automatic test_spawn_unaligned_base();
        write_stack_base(32'hFFFF_FFFF);
        send_item(OP_SPAWN, $urandom(), $urandom());
        send_item(OP_SWITCH, $urandom(), $urandom());
        wait_results_drained();
    endtask

    task automatic test_random_fill();
        write_stack_base($urandom() & 32'hFFFF_FFF0);
        run_random_items(60, 8);
        wait_results_drained();
    endtask

    task automatic test_table_full();
        while (tasks_taken < SLOTS) send_item(OP_SPAWN, $urandom(), $urandom());
        send_item(OP_SPAWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_SPAWN, 32'h0000_0000, 32'h0000_0000);
        send_item(OP_SWITCH, $urandom(), $urandom());
        send_item(OP_SWITCH, $urandom(), $urandom());
        wait_results_drained();
    endtask

    task automatic test_random_full_table();
        write_stack_base($urandom());
        run_random_items(100, 4);
        wait_results_drained();
    endtask

    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(16, 96);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 1) == 1);
            default: m_tready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    always @(posedge aclk) begin
        sched_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (sched_results_q.size() == 0) begin
                $error("Unexpected result transfer: value %h", m_tdata[31:0]);
                errors++;
            end else begin
                exp_r = sched_results_q.pop_front();
                if (m_tuser !== exp_r.kind) begin
                    $error("kind: expected %0d, got %0d", exp_r.kind, m_tuser);
                    errors++;
                end
                if (m_tdata[31:0] !== exp_r.value) begin
                    $error("value: expected %h, got %h", exp_r.value, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== exp_r.wdata) begin
                    $error("write_data: expected %h, got %h", exp_r.wdata,
                           m_tdata[63:32]);
                    errors++;
                end
                if (m_tlast !== exp_r.last) begin
                    $error("last: expected %0d, got %0d", exp_r.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("round_robin_task_switcher_top test failed");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_single_task_switch();
        test_spawn_base_zero();
        test_spawn_wrapped_base();
        test_spawn_unaligned_base();
        test_random_fill();
        test_table_full();
        test_random_full_table();
        wait_results_drained();
        if (errors == 0) begin
            $display("round_robin_task_switcher_top test passed");
        end else begin
            $display("round_robin_task_switcher_top test failed");
        end
        $finish;
    end

endmodule
